// ===== sv/ffc_pkg.sv =====
// ----------------------------------------------------------------------------
// ffc_pkg
// Shared types and op codes of the float format converter.
// ----------------------------------------------------------------------------
package ffc_pkg;

	typedef enum logic [2:0] {
		OP_H2F = 3'd0,
		OP_F2H = 3'd1,
		OP_B2F = 3'd2,
		OP_F2B = 3'd3,
		OP_Q2F = 3'd4,
		OP_F2Q = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [31:0] result;
	} rsp_t;

endpackage

// ===== sv/ffc_if.sv =====
// ----------------------------------------------------------------------------
// ffc_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface ffc_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/ffc_pipe.sv =====
// ----------------------------------------------------------------------------
// ffc_pipe
// Three-stage conversion datapath: decode, normalize/shift, assemble.
// ----------------------------------------------------------------------------
module ffc_pipe (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [2:0]  op,
	input  logic [31:0] value,
	output logic        out_valid,
	output logic [31:0] result
);

	// stage 1: field decode, leading-one position of narrow subnormals
	logic        v_s1;
	logic [2:0]  op_s1;
	logic [31:0] val_s1;
	logic [3:0]  lz_s1;
	logic [3:0]  lz;
	logic [9:0]  hm;

	always_comb begin
		hm = value[9:0];
		lz = 4'd0;
		if (op == ffc_pkg::OP_H2F) begin
			for (int i = 0; i < 10; i++)
				if (hm[i]) lz = 4'(10 - i);
		end else begin
			for (int i = 0; i < 3; i++)
				if (value[i]) lz = 4'(3 - i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= op;
			val_s1 <= value;
			lz_s1  <= lz;
		end
	end

	// stage 2: mantissa shifts and bf16 rounding add
	logic        v_s2;
	logic [2:0]  op_s2;
	logic [31:0] val_s2;
	logic [3:0]  lz_s2;
	logic [10:0] hsub_s2;
	logic [23:0] fsh_s2;
	logic [31:0] bsum_s2;
	logic [7:0]  fe;
	logic [23:0] fsh;

	always_comb begin
		fe = val_s1[30:23];
		fsh = 24'd0;
		if (op_s1 == ffc_pkg::OP_F2H) begin
			if (fe >= 8'd103 && fe <= 8'd112)
				fsh = {1'b1, val_s1[22:0]} >> (8'd113 - fe);
		end else if (fe >= 8'd118 && fe <= 8'd120) begin
			fsh = {1'b1, val_s1[22:0]} >> (8'd121 - fe);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			op_s2   <= op_s1;
			val_s2  <= val_s1;
			lz_s2   <= lz_s1;
			hsub_s2 <= {1'b0, val_s1[9:0]} << lz_s1;
			fsh_s2  <= fsh;
			bsum_s2 <= val_s1 + 32'h0000_7FFF + {31'd0, val_s1[16]};
		end
	end

	// stage 3: assemble
	logic        v_s3;
	logic [31:0] res_s3;
	logic [31:0] r;
	logic [7:0]  e8;
	logic [4:0]  he;
	logic [3:0]  qe;
	logic [2:0]  qsub;

	always_comb begin
		e8 = val_s2[30:23];
		he = val_s2[14:10];
		qe = val_s2[6:3];
		qsub = 3'(val_s2[2:0] << lz_s2);
		r = 32'd0;
		case (op_s2)
			ffc_pkg::OP_H2F: begin
				if (he == 5'd31)
					r = {val_s2[15], 8'hFF, val_s2[9:0], 13'd0};
				else if (he == 5'd0) begin
					if (val_s2[9:0] == 10'd0) r = {val_s2[15], 31'd0};
					else r = {val_s2[15], 8'(8'd113 - {4'd0, lz_s2}),
						hsub_s2[9:0], 13'd0};
				end else
					r = {val_s2[15], 8'({3'd0, he} + 8'd112), val_s2[9:0], 13'd0};
			end
			ffc_pkg::OP_F2H: begin
				if (e8 >= 8'd143) begin
					if (e8 == 8'hFF && val_s2[22:0] != 23'd0)
						r = {16'd0, val_s2[31], 15'h7E00};
					else r = {16'd0, val_s2[31], 15'h7C00};
				end else if (e8 >= 8'd113)
					r = {16'd0, val_s2[31], 5'(e8 - 8'd112), val_s2[22:13]};
				else if (e8 >= 8'd103)
					r = {16'd0, val_s2[31], 5'd0, fsh_s2[22:13]};
				else r = {16'd0, val_s2[31], 15'd0};
			end
			ffc_pkg::OP_B2F: r = {val_s2[15:0], 16'd0};
			ffc_pkg::OP_F2B: r = {16'd0, bsum_s2[31:16]};
			ffc_pkg::OP_Q2F: begin
				if (qe == 4'hF && val_s2[2:0] == 3'd7)
					r = {val_s2[7], 31'h7FC0_0000};
				else if (qe == 4'd0) begin
					if (val_s2[2:0] == 3'd0) r = {val_s2[7], 31'd0};
					else r = {val_s2[7], 8'(8'd121 - {4'd0, lz_s2}), qsub, 20'd0};
				end else
					r = {val_s2[7], 8'({4'd0, qe} + 8'd120), val_s2[2:0], 20'd0};
			end
			ffc_pkg::OP_F2Q: begin
				if (e8 > 8'd135)
					r = {24'd0, val_s2[31], 7'h7E};
				else if (e8 >= 8'd121) begin
					if (e8 == 8'd135 && val_s2[22:20] == 3'd7)
						r = {24'd0, val_s2[31], 7'h7E};
					else r = {24'd0, val_s2[31], 4'(e8 - 8'd120), val_s2[22:20]};
				end else if (e8 >= 8'd118)
					r = {24'd0, val_s2[31], 4'd0, fsh_s2[22:20]};
				else r = {24'd0, val_s2[31], 7'd0};
			end
			default: r = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) res_s3 <= r;
	end

	assign out_valid = v_s3;
	assign result    = res_s3;

	a_b2f: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s2 && op_s2 == ffc_pkg::OP_B2F) |=> res_s3[15:0] == 16'd0)
		else $error("bf16 widen low bits");
	a_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s2 && (op_s2 == ffc_pkg::OP_F2H || op_s2 == ffc_pkg::OP_F2B))
		|=> res_s3[31:16] == 16'd0)
		else $error("narrow upper bits");
	a_vflow: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> v_s3 == $past(v_s2))
		else $error("valid flow");

endmodule

// ===== sv/float_format_converter_unit.sv =====
// ----------------------------------------------------------------------------
// float_format_converter_unit
// Converts between fp32 and fp16, bf16, fp8 E4M3 bit patterns.
// Pipeline: decode, shift and assemble stages.
// Throughput: one item per cycle; a stall at the output freezes all stages.
// Reset: arst_n clears the stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module float_format_converter_unit (
	input  logic  clk,
	input  logic  arst_n,
	ffc_if.sink   in_ch,
	ffc_if.source out_ch
);

	ffc_pkg::req_t req;
	logic          en;
	logic          ov;
	logic [31:0]   res;

	assign req = ffc_pkg::req_t'(in_ch.data[34:0]);
	assign en  = out_ch.ready || !ov;
	assign in_ch.ready = en;

	ffc_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_ch.valid),
		.op        (req.op),
		.value     (req.value),
		.out_valid (ov),
		.result    (res)
	);

	assign out_ch.valid = ov;
	assign out_ch.data  = res;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.data))
		else $error("output not held");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the float format converter against a bit-exact predictor of all six
// conversions. Directed corner values come first, then random items, some built
// around exponent boundaries, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;

	logic clk;
	logic arst_n;

	ffc_if #(.W($bits(ffc_pkg::req_t))) in_ch ();
	ffc_if #(.W($bits(ffc_pkg::rsp_t))) out_ch ();

	float_format_converter_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	logic [31:0] expected_q[$];
	int errors = 0;
	bit sending_done = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [31:0] h16_to_f32(logic [15:0] v);
		logic [31:0] s;
		logic [4:0] ex;
		logic [10:0] man;
		logic [7:0] e;
		s = {v[15], 31'd0};
		ex = v[14:10];
		man = {1'b0, v[9:0]};
		e = 8'd113;
		if (ex == 5'd31) return s | 32'h7F800000 | (32'(man[9:0]) << 13);
		if (ex == 5'd0) begin
			if (man == 0) return s;
			while (!man[10]) begin
				man = man << 1;
				e = e - 1;
			end
			return s | (32'(e) << 23) | (32'(man[9:0]) << 13);
		end
		return s | (32'(ex + 8'd112) << 23) | (32'(man[9:0]) << 13);
	endfunction

	function automatic logic [31:0] f32_to_h16(logic [31:0] v);
		logic [31:0] s;
		int ex;
		logic [31:0] man;
		s = (v >> 16) & 32'h8000;
		ex = int'(v[30:23]) - 127;
		man = v & 32'h7FFFFF;
		if (ex >= 16) begin
			if (ex == 128 && man != 0) return s | 32'h7E00;
			return s | 32'h7C00;
		end
		if (ex >= -14) return s | (32'(ex + 15) << 10) | (man >> 13);
		if (ex >= -24) begin
			man = (man | 32'h800000) >> (-14 - ex);
			return s | (man >> 13);
		end
		return s;
	endfunction

	function automatic logic [31:0] f32_to_b16(logic [31:0] v);
		logic [31:0] sum;
		sum = v + 32'h00007FFF + 32'(v[16]);
		return {16'd0, sum[31:16]};
	endfunction

	function automatic logic [31:0] e4m3_to_f32(logic [7:0] v);
		logic [31:0] s;
		logic [3:0] ex;
		logic [3:0] man;
		logic [7:0] e;
		s = {v[7], 31'd0};
		ex = v[6:3];
		man = {1'b0, v[2:0]};
		e = 8'd121;
		if (ex == 4'd15 && man == 4'd7) return s | 32'h7FC00000;
		if (ex == 4'd0) begin
			if (man == 0) return s;
			while (!man[3]) begin
				man = man << 1;
				e = e - 1;
			end
			return s | (32'(e) << 23) | (32'(man[2:0]) << 20);
		end
		return s | (32'(ex + 8'd120) << 23) | (32'(man[2:0]) << 20);
	endfunction

	function automatic logic [31:0] f32_to_e4m3(logic [31:0] v);
		logic [31:0] s;
		int ex;
		logic [31:0] full;
		logic [31:0] e;
		logic [31:0] m;
		s = (v >> 24) & 32'h80;
		ex = int'(v[30:23]) - 127;
		if (ex > 8) return s | 32'h7E;
		if (ex >= -6) begin
			e = 32'(ex + 7);
			m = 32'(v[22:20]);
			if (e == 15 && m == 7) return s | 32'h7E;
			return s | (e << 3) | m;
		end
		if (ex >= -9) begin
			full = (v & 32'h7FFFFF | 32'h800000) >> (-6 - ex);
			return s | ((full >> 20) & 32'h7);
		end
		return s;
	endfunction

	function automatic logic [31:0] convert(logic [2:0] op, logic [31:0] v);
		case (op)
			ffc_pkg::OP_H2F: return h16_to_f32(v[15:0]);
			ffc_pkg::OP_F2H: return f32_to_h16(v);
			ffc_pkg::OP_B2F: return {v[15:0], 16'd0};
			ffc_pkg::OP_F2B: return f32_to_b16(v);
			ffc_pkg::OP_Q2F: return e4m3_to_f32(v[7:0]);
			ffc_pkg::OP_F2Q: return f32_to_e4m3(v);
			default: return 32'd0;
		endcase
	endfunction

	task automatic send_item(logic [2:0] op, logic [31:0] v);
		ffc_pkg::req_t r;
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		r.op = op;
		r.value = v;
		in_ch.data <= r;
		in_ch.valid <= 1'b1;
		expected_q.push_back(convert(op, v));
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
	endtask

	// float with chosen exponent, random sign and mantissa
	function automatic logic [31:0] f32_near(int e);
		return {1'($urandom), 8'(e), 23'($urandom)};
	endfunction

	task automatic test_directed();
		logic [31:0] vals[] = '{32'h0, 32'h80000000, 32'hFFFFFFFF, 32'h7F800000,
			32'hFF800000, 32'h7FC00001, 32'h477FE000, 32'h47800000, 32'h33800000,
			32'h337FFFFF, 32'h43E00000, 32'h43E80000, 32'h3B000000, 32'h7F7FFFFF,
			32'hFFFF7F7F, 32'h0000FC01, 32'h7C00, 32'h03FF, 32'h0001, 32'h7F,
			32'hFF, 32'h01};
		foreach (vals[i]) send_item(3'(i % 8), vals[i]);
		send_item(3'd6, 32'h12345678);
		send_item(3'd7, 32'hFFFFFFFF);
		wait_drain();
	endtask

	task automatic test_random();
		logic [2:0] op;
		logic [31:0] v;
		for (int i = 0; i < 750; i++) begin
			op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			case ($urandom_range(0, 3))
				0: v = $urandom;
				1: v = f32_near($urandom_range(100, 150));
				2: v = f32_near($urandom_range(0, 1) ? 0 : 255);
				default: v = {16'($urandom), 16'($urandom)};
			endcase
			send_item(op, v);
			if (i == 300) wait_drain();
		end
	endtask

	// output stall of random length, drawn anew for each item
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = $urandom_range(0, 4);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		ffc_pkg::rsp_t rsp;
		logic [31:0] want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			rsp = out_ch.data;
			if (expected_q.size() == 0) begin
				$display("%0t unexpected item: expected none, actual %h", $time, rsp.result);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (rsp.result !== want) begin
					$display("%0t result mismatch: expected %h, actual %h",
						$time, want, rsp.result);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random();
		wait_drain();
		repeat (20) @(negedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
